// ===== hw/rtl/twpb_pkg.sv =====
// ----------------------------------------------------------------------------
// twpb_pkg : shared types and constants for the tiled watermark blend core
// Item layouts, register indexes, command codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package twpb_pkg;

  // Fixed field widths
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int WEIGHT_W   = 9;
  localparam int DIM_REG_W  = 7;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Coordinate range accepted for marking
  localparam int IMAGE_MAX_DIM = 4096;

  // Remainder pipeline: bits of a coordinate resolved per stage
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = COORD_W / DIV_STEP;

  // Blend weight of 1.0
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 9'd0;
  localparam int                  MARK_DIM_RST  = 64;
  localparam logic                THREE_CH_RST  = 1'b1;
  localparam logic [LIMIT_W-1:0]  DARK_LIMIT_RST = 10'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_WEIGHT  = 3'd0,
    CFG_MARK_WIDTH    = 3'd1,
    CFG_MARK_HEIGHT   = 3'd2,
    CFG_THREE_CHANNEL = 3'd3,
    CFG_DARK_LIMIT    = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MARK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [CHAN_W-1:0]  chan_zero;
    logic [CHAN_W-1:0]  chan_one;
    logic [CHAN_W-1:0]  chan_two;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_zero;
    logic [CHAN_W-1:0] out_one;
    logic [CHAN_W-1:0] out_two;
    logic              was_marked;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/twpb_ram.sv =====
// ----------------------------------------------------------------------------
// twpb_ram : simple dual-port RAM
// One write port, one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module twpb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tiled_watermark_pixel_blend_core.sv =====
// ----------------------------------------------------------------------------
// tiled_watermark_pixel_blend_core : tiled watermark alpha blend
// Loads a watermark into on-chip RAM, then blends streamed pixels with the
// texel at (col mod width, row mod height).
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | in        | in_valid/in_stall  | in_data  (load texel/mark px)
//  out_    | out       | out_valid/out_stall| out_data (one per mark item)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; stages from accept to out_valid:
// (input reg, 4 remainder stages, RAM read, multiply, output reg).
// Remainders are built 3 bits per stage by restoring compare/subtract.
// Loads write the RAM in the same stage where marks read it, so order holds.
// Synchronous active-low reset clears valid bits and sets the config registers
// to their reset values; RAM is not cleared. A full stage holds only while the stage after it holds,
// so bubbles are squeezed out; out_stall reaches in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_watermark_pixel_blend_core #(
  parameter int MARK_MAX_DIM = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input item channel
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire twpb_pkg::in_item_t                  in_data,
  // result item channel
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      twpb_pkg::out_item_t                 out_data,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [twpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [twpb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Derived sizes
  localparam int DIM_W   = $clog2(MARK_MAX_DIM + 1);
  localparam int IDX_W   = (MARK_MAX_DIM > 1) ? $clog2(MARK_MAX_DIM) : 1;
  localparam int DEPTH   = MARK_MAX_DIM * MARK_MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_RST = (MARK_MAX_DIM < twpb_pkg::MARK_DIM_RST) ?
                           MARK_MAX_DIM : twpb_pkg::MARK_DIM_RST;
  localparam logic [AW-1:0] ROW_PITCH = AW'(MARK_MAX_DIM);

  localparam int CW     = twpb_pkg::CHAN_W;
  localparam int PROD_W = twpb_pkg::CHAN_W + twpb_pkg::WEIGHT_W;

  // Stage map
  localparam int NDIV    = twpb_pkg::DIV_STAGES;
  localparam int ST_MEM  = NDIV + 1;
  localparam int ST_MUL  = NDIV + 2;
  localparam int ST_OUT  = NDIV + 3;
  localparam int NST     = NDIV + 4;

  typedef struct packed {
    twpb_pkg::in_item_t px;
    logic               in_img;
    logic               load_ok;
    logic [DIM_W-1:0]   rem_row;
    logic [DIM_W-1:0]   rem_col;
  } div_item_t;

  typedef struct packed {
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic [CW-1:0] c2;
    logic          in_img;
  } mem_item_t;

  typedef struct packed {
    logic [PROD_W-1:0] pp0;
    logic [PROD_W-1:0] pp1;
    logic [PROD_W-1:0] pp2;
    logic [PROD_W-1:0] wp0;
    logic [PROD_W-1:0] wp1;
    logic [PROD_W-1:0] wp2;
    logic [CW-1:0]     c0;
    logic [CW-1:0]     c1;
    logic [CW-1:0]     c2;
    logic              in_img;
    logic              dark_ok;
  } mul_item_t;

  // --------------------------------------------------------------------------
  // Configuration (stored already clamped)
  // --------------------------------------------------------------------------
  logic [twpb_pkg::WEIGHT_W-1:0] weight_r;
  logic [DIM_W-1:0]              mark_w_r;
  logic [DIM_W-1:0]              mark_h_r;
  logic                          three_ch_r;
  logic [twpb_pkg::LIMIT_W-1:0]  dark_limit_r;

  function automatic logic [DIM_W-1:0] clamp_dim(
    input logic [twpb_pkg::DIM_REG_W-1:0] v
  );
    logic [DIM_W-1:0] d;
    begin
      if (v == '0) begin
        d = DIM_W'(1);
      end else if (32'(v) > 32'(MARK_MAX_DIM)) begin
        d = DIM_W'(MARK_MAX_DIM);
      end else begin
        d = DIM_W'(v);
      end
      return d;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r     <= twpb_pkg::WEIGHT_RST;
      mark_w_r     <= DIM_W'(DIM_RST);
      mark_h_r     <= DIM_W'(DIM_RST);
      three_ch_r   <= twpb_pkg::THREE_CH_RST;
      dark_limit_r <= twpb_pkg::DARK_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        twpb_pkg::CFG_BLEND_WEIGHT: begin
          if (cfg_wdata[twpb_pkg::WEIGHT_W-1:0] > twpb_pkg::WEIGHT_FULL) begin
            weight_r <= twpb_pkg::WEIGHT_FULL;
          end else begin
            weight_r <= cfg_wdata[twpb_pkg::WEIGHT_W-1:0];
          end
        end
        twpb_pkg::CFG_MARK_WIDTH: begin
          mark_w_r <= clamp_dim(cfg_wdata[twpb_pkg::DIM_REG_W-1:0]);
        end
        twpb_pkg::CFG_MARK_HEIGHT: begin
          mark_h_r <= clamp_dim(cfg_wdata[twpb_pkg::DIM_REG_W-1:0]);
        end
        twpb_pkg::CFG_THREE_CHANNEL: begin
          three_ch_r <= cfg_wdata[0];
        end
        twpb_pkg::CFG_DARK_LIMIT: begin
          dark_limit_r <= cfg_wdata[twpb_pkg::LIMIT_W-1:0];
        end
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when empty or when its content moves on
  // --------------------------------------------------------------------------
  logic vld_r [NST];
  logic take  [NST];

  always_comb begin
    take[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      take[i] = !vld_r[i] || take[i+1];
    end
  end

  assign in_stall = !take[0];

  div_item_t div_r [NDIV+1];
  mem_item_t mem_r;
  mul_item_t mul_r;
  twpb_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (take[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (take[i]) begin
          if (i == ST_MEM) begin
            // loads end here: they leave no result
            vld_r[i] <= vld_r[i-1] &&
                        (div_r[NDIV].px.command == twpb_pkg::CMD_MARK);
          end else begin
            vld_r[i] <= vld_r[i-1];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (take[0]) begin
      div_r[0].px      <= in_data;
      div_r[0].in_img  <= (32'(in_data.pixel_row) < twpb_pkg::IMAGE_MAX_DIM) &&
                          (32'(in_data.pixel_col) < twpb_pkg::IMAGE_MAX_DIM);
      div_r[0].load_ok <= (32'(in_data.pixel_row) < 32'(MARK_MAX_DIM)) &&
                          (32'(in_data.pixel_col) < 32'(MARK_MAX_DIM));
      div_r[0].rem_row <= '0;
      div_r[0].rem_col <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Remainder stages: restoring steps, MSB first
  // --------------------------------------------------------------------------
  function automatic logic [DIM_W-1:0] mod_step(
    input logic [DIM_W-1:0] rem,
    input logic             nb,
    input logic [DIM_W-1:0] d
  );
    logic [DIM_W:0] sh;
    begin
      sh = {rem, nb};
      if (sh >= {1'b0, d}) begin
        sh = sh - {1'b0, d};
      end
      return sh[DIM_W-1:0];
    end
  endfunction

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    div_item_t div_nxt;

    always_comb begin
      div_nxt = div_r[j-1];
      for (int b = 0; b < twpb_pkg::DIV_STEP; b++) begin
        div_nxt.rem_row = mod_step(div_nxt.rem_row,
          div_r[j-1].px.pixel_row[twpb_pkg::COORD_W - 1 - (j-1)*twpb_pkg::DIV_STEP - b],
          mark_h_r);
        div_nxt.rem_col = mod_step(div_nxt.rem_col,
          div_r[j-1].px.pixel_col[twpb_pkg::COORD_W - 1 - (j-1)*twpb_pkg::DIV_STEP - b],
          mark_w_r);
      end
    end

    always_ff @(posedge clk) begin
      if (take[j]) begin
        div_r[j] <= div_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // RAM stage: loads write, marks read, at one address mux
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] ri;
  logic [IDX_W-1:0] ci;
  logic [AW-1:0]    addr;
  logic             is_load;
  logic             ram_we;
  logic [3*CW-1:0]  texel;

  assign is_load = (div_r[NDIV].px.command == twpb_pkg::CMD_LOAD);

  always_comb begin
    if (is_load) begin
      ri = IDX_W'(div_r[NDIV].px.pixel_row);
      ci = IDX_W'(div_r[NDIV].px.pixel_col);
    end else begin
      ri = IDX_W'(div_r[NDIV].rem_row);
      ci = IDX_W'(div_r[NDIV].rem_col);
    end
    addr = AW'(ri) * ROW_PITCH + AW'(ci);
  end

  assign ram_we = take[ST_MEM] && vld_r[NDIV] && is_load && div_r[NDIV].load_ok;

  twpb_ram #(
    .WIDTH (3 * CW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({div_r[NDIV].px.chan_two, div_r[NDIV].px.chan_one,
             div_r[NDIV].px.chan_zero}),
    .re    (take[ST_MEM]),
    .raddr (addr),
    .rdata (texel)
  );

  always_ff @(posedge clk) begin
    if (take[ST_MEM]) begin
      mem_r.c0     <= div_r[NDIV].px.chan_zero;
      mem_r.c1     <= div_r[NDIV].px.chan_one;
      mem_r.c2     <= div_r[NDIV].px.chan_two;
      mem_r.in_img <= div_r[NDIV].in_img;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: p*(256-k) and w*k per channel, dark test
  // --------------------------------------------------------------------------
  logic [twpb_pkg::WEIGHT_W-1:0] inv_w;
  logic [CW-1:0]                 t0;
  logic [CW-1:0]                 t1;
  logic [CW-1:0]                 t2;
  logic [twpb_pkg::LIMIT_W-1:0]  tsum;

  assign inv_w = twpb_pkg::WEIGHT_FULL - weight_r;
  assign t0    = texel[CW-1:0];
  assign t1    = texel[2*CW-1:CW];
  assign t2    = texel[3*CW-1:2*CW];
  assign tsum  = twpb_pkg::LIMIT_W'(t0) + twpb_pkg::LIMIT_W'(t1) +
                 twpb_pkg::LIMIT_W'(t2);

  always_ff @(posedge clk) begin
    if (take[ST_MUL]) begin
      mul_r.pp0     <= PROD_W'(mem_r.c0) * PROD_W'(inv_w);
      mul_r.pp1     <= PROD_W'(mem_r.c1) * PROD_W'(inv_w);
      mul_r.pp2     <= PROD_W'(mem_r.c2) * PROD_W'(inv_w);
      mul_r.wp0     <= PROD_W'(t0) * PROD_W'(weight_r);
      mul_r.wp1     <= PROD_W'(t1) * PROD_W'(weight_r);
      mul_r.wp2     <= PROD_W'(t2) * PROD_W'(weight_r);
      mul_r.c0      <= mem_r.c0;
      mul_r.c1      <= mem_r.c1;
      mul_r.c2      <= mem_r.c2;
      mul_r.in_img  <= mem_r.in_img;
      mul_r.dark_ok <= (tsum < dark_limit_r);
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sum, >>8, mode select
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]   s0;
  logic [PROD_W-1:0]   s1;
  logic [PROD_W-1:0]   s2;
  twpb_pkg::out_item_t out_nxt;

  assign s0 = mul_r.pp0 + mul_r.wp0;
  assign s1 = mul_r.pp1 + mul_r.wp1;
  assign s2 = mul_r.pp2 + mul_r.wp2;

  always_comb begin
    // pixel passes through unchanged unless blended below
    out_nxt.out_zero   = mul_r.c0;
    out_nxt.out_one    = mul_r.c1;
    out_nxt.out_two    = mul_r.c2;
    out_nxt.was_marked = 1'b0;
    if (mul_r.in_img) begin
      if (!three_ch_r) begin
        out_nxt.out_zero   = s0[2*CW-1:CW];
        out_nxt.was_marked = 1'b1;
      end else if (mul_r.dark_ok) begin
        out_nxt.out_zero   = s0[2*CW-1:CW];
        out_nxt.out_one    = s1[2*CW-1:CW];
        out_nxt.out_two    = s2[2*CW-1:CW];
        out_nxt.was_marked = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== tb/tiled_watermark_pixel_blend_core_tb.sv =====
// ----------------------------------------------------------------------------
// tiled_watermark_pixel_blend_core_tb : self-checking bench for the blend core
// Loads watermark texels and streams image pixels through the core under a
// series of register settings, predicting every result item in the bench
// and checking them in order, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_watermark_pixel_blend_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int MARK_DIM     = 64;               // watermark store is MARK_DIM x MARK_DIM
  localparam int RAM_DEPTH    = MARK_DIM * MARK_DIM;
  localparam int PHASE_ITEMS  = 150;              // random items per register setting
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_CYCLES = 16;               // idle time after the last result, lets the pipe empty
  localparam int HOLD_CYCLES  = 300;              // long receiver hold-off
  localparam int MAX_SHOWN    = 10;
  localparam int CFG_IDX_LAST = (1 << twpb_pkg::CFG_IDX_W) - 1;
  // watchdog limit on the whole run, in ns, well above what the items, gaps and stalls need
  localparam int TIMEOUT_NS   = 2_000_000;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  twpb_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  twpb_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [twpb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [twpb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  tiled_watermark_pixel_blend_core #(
    .MARK_MAX_DIM (MARK_DIM)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the core's registers and watermark store
  // --------------------------------------------------------------------------
  logic [twpb_pkg::WEIGHT_W-1:0]  cur_weight = twpb_pkg::WEIGHT_RST;
  logic [twpb_pkg::DIM_REG_W-1:0] cur_width  =
    twpb_pkg::DIM_REG_W'(twpb_pkg::MARK_DIM_RST);
  logic [twpb_pkg::DIM_REG_W-1:0] cur_height =
    twpb_pkg::DIM_REG_W'(twpb_pkg::MARK_DIM_RST);
  logic                           cur_three  = twpb_pkg::THREE_CH_RST;
  logic [twpb_pkg::LIMIT_W-1:0]   cur_limit  = twpb_pkg::DARK_LIMIT_RST;

  logic [3*twpb_pkg::CHAN_W-1:0]  texel_ram    [RAM_DEPTH];   // written on accepted loads
  bit                             texel_loaded [RAM_DEPTH];   // generator's view, on queueing

  twpb_pkg::in_item_t  pending[$];       // items waiting for the driver
  twpb_pkg::out_item_t expected_px[$];   // predicted result items, oldest first

  int n_queued  = 0;
  int n_loads   = 0;
  int n_marks   = 0;
  int n_checked = 0;
  int n_blended = 0;
  int n_errors  = 0;
  int n_phases  = 0;

  // Zero dimension reads as one, anything past the store's side as the side
  function automatic int unsigned eff_dim(input logic [twpb_pkg::DIM_REG_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > MARK_DIM) return MARK_DIM;
    return int'(d);
  endfunction

  // (p*(256-k) + t*k) >> 8, truncating
  function automatic logic [twpb_pkg::CHAN_W-1:0] mix_chan(
    input logic [twpb_pkg::CHAN_W-1:0] p,
    input logic [twpb_pkg::CHAN_W-1:0] t,
    input int unsigned k);
    int unsigned acc;
    acc = int'(p) * (int'(twpb_pkg::WEIGHT_FULL) - k) + int'(t) * k;
    return twpb_pkg::CHAN_W'(acc >> 8);
  endfunction

  // Expected result for one accepted pixel, from the current settings and store
  function automatic twpb_pkg::out_item_t blend_expected(input twpb_pkg::in_item_t px);
    int unsigned                   w, h, k, addr, tsum;
    logic [3*twpb_pkg::CHAN_W-1:0] t;
    logic [twpb_pkg::CHAN_W-1:0]   t0, t1, t2;
    twpb_pkg::out_item_t           r;
    r.out_zero   = px.chan_zero;
    r.out_one    = px.chan_one;
    r.out_two    = px.chan_two;
    r.was_marked = 1'b0;
    if (int'(px.pixel_row) < twpb_pkg::IMAGE_MAX_DIM &&
        int'(px.pixel_col) < twpb_pkg::IMAGE_MAX_DIM) begin
      w    = eff_dim(cur_width);
      h    = eff_dim(cur_height);
      k    = (cur_weight > twpb_pkg::WEIGHT_FULL) ? int'(twpb_pkg::WEIGHT_FULL) :
                                                    int'(cur_weight);
      addr = (int'(px.pixel_row) % h) * MARK_DIM + (int'(px.pixel_col) % w);
      t    = texel_ram[addr];
      t0   = t[twpb_pkg::CHAN_W-1:0];
      t1   = t[2*twpb_pkg::CHAN_W-1:twpb_pkg::CHAN_W];
      t2   = t[3*twpb_pkg::CHAN_W-1:2*twpb_pkg::CHAN_W];
      tsum = int'(t0) + int'(t1) + int'(t2);
      if (!cur_three) begin
        // one-channel: only channel 0 takes the watermark, always
        r.out_zero   = mix_chan(px.chan_zero, t0, k);
        r.was_marked = 1'b1;
      end else if (tsum < int'(cur_limit)) begin
        r.out_zero   = mix_chan(px.chan_zero, t0, k);
        r.out_one    = mix_chan(px.chan_one, t1, k);
        r.out_two    = mix_chan(px.chan_two, t2, k);
        r.was_marked = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: prediction on input accept, checking on result accept
  // --------------------------------------------------------------------------
  logic                in_took = 1'b0;   // item accepted at the last rising edge
  twpb_pkg::out_item_t want;

  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      if (in_data.command == twpb_pkg::CMD_LOAD) begin
        n_loads++;
        // loads outside the store are dropped by the core
        if (int'(in_data.pixel_row) < MARK_DIM && int'(in_data.pixel_col) < MARK_DIM)
          texel_ram[int'(in_data.pixel_row) * MARK_DIM + int'(in_data.pixel_col)] =
            {in_data.chan_two, in_data.chan_one, in_data.chan_zero};
      end else begin
        n_marks++;
        expected_px = {expected_px, blend_expected(in_data)};
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        note_failure($sformatf("result item with nothing expected: %0h/%0h/%0h marked %0b",
                               out_data.out_zero, out_data.out_one, out_data.out_two,
                               out_data.was_marked));
      end else begin
        want = expected_px.pop_front();
        n_checked++;
        if (want.was_marked) n_blended++;
        if (out_data.out_zero !== want.out_zero || out_data.out_one !== want.out_one ||
            out_data.out_two !== want.out_two || out_data.was_marked !== want.was_marked)
          note_failure($sformatf(
            "result %0d mismatch: expected %0h/%0h/%0h marked %0b, got %0h/%0h/%0h marked %0b",
            n_checked, want.out_zero, want.out_one, want.out_two, want.was_marked,
            out_data.out_zero, out_data.out_one, out_data.out_two, out_data.was_marked));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of items with random gaps; a stalled item is held as is
  // --------------------------------------------------------------------------
  int tx_burst = 1;
  int tx_gap   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
        if (tx_burst <= 1) begin
          tx_burst = $urandom_range(1, 48);
          // a quarter of the bursts run straight into the next one
          tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          tx_burst--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switched at random, plus one long hold-off
  // taken while the sender still has plenty queued, so the core backs up
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_FREE;
  int       rx_left   = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_marks >= 400 && pending.size() > 60) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 128);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:  out_stall <= ((rx_left % 8) < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [twpb_pkg::CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return twpb_pkg::CHAN_W'($urandom);
    endcase
  endfunction

  // half the time near the origin, otherwise anywhere in the 12-bit range
  function automatic logic [twpb_pkg::COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 1) == 0) return twpb_pkg::COORD_W'($urandom_range(0, 255));
    return twpb_pkg::COORD_W'($urandom);
  endfunction

  task automatic queue_load(input logic [twpb_pkg::COORD_W-1:0] row,
                            input logic [twpb_pkg::COORD_W-1:0] col,
                            input logic [twpb_pkg::CHAN_W-1:0] c0,
                            input logic [twpb_pkg::CHAN_W-1:0] c1,
                            input logic [twpb_pkg::CHAN_W-1:0] c2);
    twpb_pkg::in_item_t item;
    item = '{command: twpb_pkg::CMD_LOAD, pixel_row: row, pixel_col: col,
             chan_zero: c0, chan_one: c1, chan_two: c2};
    pending = {pending, item};
    n_queued++;
    if (int'(row) < MARK_DIM && int'(col) < MARK_DIM)
      texel_loaded[int'(row) * MARK_DIM + int'(col)] = 1'b1;
  endtask

  // A pixel whose texel has never been loaded gets a random texel loaded first,
  // so the core never reads an unwritten store entry.
  task automatic queue_mark(input logic [twpb_pkg::COORD_W-1:0] row,
                            input logic [twpb_pkg::COORD_W-1:0] col,
                            input logic [twpb_pkg::CHAN_W-1:0] c0,
                            input logic [twpb_pkg::CHAN_W-1:0] c1,
                            input logic [twpb_pkg::CHAN_W-1:0] c2);
    int unsigned        tr, tc;
    twpb_pkg::in_item_t item;
    tr = int'(row) % eff_dim(cur_height);
    tc = int'(col) % eff_dim(cur_width);
    if (!texel_loaded[tr * MARK_DIM + tc])
      queue_load(twpb_pkg::COORD_W'(tr), twpb_pkg::COORD_W'(tc),
                 rand_chan(), rand_chan(), rand_chan());
    item = '{command: twpb_pkg::CMD_MARK, pixel_row: row, pixel_col: col,
             chan_zero: c0, chan_one: c1, chan_two: c2};
    pending = {pending, item};
    n_queued++;
  endtask

  // Every queued item accepted and every result back, then let the pipe empty
  task automatic wait_idle();
    while (n_loads + n_marks != n_queued || expected_px.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; the bench copy keeps only the bits the register holds
  task automatic set_reg(input logic [twpb_pkg::CFG_IDX_W-1:0] idx,
                         input logic [twpb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      twpb_pkg::CFG_BLEND_WEIGHT:  cur_weight = val[twpb_pkg::WEIGHT_W-1:0];
      twpb_pkg::CFG_MARK_WIDTH:    cur_width  = val[twpb_pkg::DIM_REG_W-1:0];
      twpb_pkg::CFG_MARK_HEIGHT:   cur_height = val[twpb_pkg::DIM_REG_W-1:0];
      twpb_pkg::CFG_THREE_CHANNEL: cur_three  = val[0];
      twpb_pkg::CFG_DARK_LIMIT:    cur_limit  = val[twpb_pkg::LIMIT_W-1:0];
      default: ;  // spare indexes change nothing
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Full register set; junk in the unused upper data bits must be dropped
  task automatic configure(input logic [twpb_pkg::WEIGHT_W-1:0] k,
                           input logic [twpb_pkg::DIM_REG_W-1:0] w,
                           input logic [twpb_pkg::DIM_REG_W-1:0] h, input logic tc,
                           input logic [twpb_pkg::LIMIT_W-1:0] lim);
    wait_idle();
    set_reg(twpb_pkg::CFG_BLEND_WEIGHT,
            {(twpb_pkg::CFG_DATA_W-twpb_pkg::WEIGHT_W)'($urandom), k});
    set_reg(twpb_pkg::CFG_MARK_WIDTH,
            {(twpb_pkg::CFG_DATA_W-twpb_pkg::DIM_REG_W)'($urandom), w});
    set_reg(twpb_pkg::CFG_MARK_HEIGHT,
            {(twpb_pkg::CFG_DATA_W-twpb_pkg::DIM_REG_W)'($urandom), h});
    set_reg(twpb_pkg::CFG_THREE_CHANNEL, {(twpb_pkg::CFG_DATA_W-1)'($urandom), tc});
    set_reg(twpb_pkg::CFG_DARK_LIMIT,    lim);
    n_phases++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int unsigned                  sel;
  logic [twpb_pkg::COORD_W-1:0] r_row, r_col;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings first: weight 0, 64x64 tile, limit 500
    n_phases = 1;
    queue_load(0, 0, 8'd0, 8'd0, 8'd0);
    queue_load(MARK_DIM - 1, MARK_DIM - 1, 8'd255, 8'd255, 8'd255);
    queue_load(0, MARK_DIM - 1, 8'd255, 8'd0, 8'd0);
    queue_load(MARK_DIM - 1, 0, 8'd10, 8'd20, 8'd30);
    queue_load(0, 5, 8'd1, 8'd2, 8'd3);
    queue_load(1, 5, 8'd4, 8'd5, 8'd6);
    // loads off the store must not alias onto (0,5) or (1,5)
    queue_load(MARK_DIM, 5, 8'd200, 8'd200, 8'd200);
    queue_load(0, MARK_DIM + 5, 8'd77, 8'd88, 8'd99);
    queue_load('1, '1, 8'd9, 8'd9, 8'd9);
    queue_mark(0, 0, 8'd255, 8'd255, 8'd255);        // dark texel, weight 0
    queue_mark('1, '1, 8'd0, 8'd0, 8'd0);            // bright texel, passes through
    queue_mark('1, 0, 8'd128, 8'd64, 8'd32);

    // full weight: dark enough texels come out as the texel itself
    configure(twpb_pkg::WEIGHT_FULL, MARK_DIM, MARK_DIM, 1'b1, 10'd766);
    queue_mark(0, 5, 8'd50, 8'd60, 8'd70);
    queue_mark(1, 5, 8'd50, 8'd60, 8'd70);
    queue_mark(MARK_DIM - 1, MARK_DIM - 1, 8'd0, 8'd0, 8'd0);   // sum 765 just under limit
    queue_mark(0, MARK_DIM - 1, 8'd255, 8'd255, 8'd255);
    queue_mark('1, twpb_pkg::COORD_W'(4031), 8'd17, 8'd34, 8'd51);   // tiles onto (63,63)

    // limit exactly at the brightest sum: no blend
    configure(twpb_pkg::WEIGHT_FULL, MARK_DIM, MARK_DIM, 1'b1, 10'd765);
    queue_mark(MARK_DIM - 1, MARK_DIM - 1, 8'd1, 8'd2, 8'd3);
    queue_mark(0, 0, 8'd255, 8'd0, 8'd255);

    // Random part: one register setting per phase, extremes included
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(9'd128, 7'd64, 7'd64, 1'b1, 10'd500);
        1: configure(twpb_pkg::WEIGHT_FULL, 7'd1, 7'd1, 1'b1, 10'd766);
        2: configure('1, 7'd0, 7'd0, 1'b0, 10'd0);             // saturating weight, zero dims
        3: begin
          configure(twpb_pkg::WEIGHT_W'($urandom), '1, 7'd37, 1'b1, '1);  // oversize width
          for (int i = twpb_pkg::CFG_DARK_LIMIT + 1; i <= CFG_IDX_LAST; i++)
            set_reg(twpb_pkg::CFG_IDX_W'(i), twpb_pkg::CFG_DATA_W'($urandom));
        end
        4: configure(9'd300, 7'd7, 7'd64, 1'b0, twpb_pkg::LIMIT_W'($urandom));
        5: configure(twpb_pkg::WEIGHT_W'($urandom),
                     twpb_pkg::DIM_REG_W'($urandom_range(1, 64)),
                     twpb_pkg::DIM_REG_W'($urandom_range(1, 64)), 1'b1, 10'd0);
        6: configure(9'd1, 7'd3, 7'd5, 1'b1, twpb_pkg::LIMIT_W'($urandom));
        default: configure(9'd0, twpb_pkg::DIM_REG_W'($urandom),
                           twpb_pkg::DIM_REG_W'($urandom), 1'($urandom),
                           twpb_pkg::LIMIT_W'($urandom));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          queue_mark(rand_coord(), rand_coord(), rand_chan(), rand_chan(), rand_chan());
        end else if (sel < 90) begin
          queue_load(twpb_pkg::COORD_W'($urandom_range(0, MARK_DIM - 1)),
                     twpb_pkg::COORD_W'($urandom_range(0, MARK_DIM - 1)),
                     rand_chan(), rand_chan(), rand_chan());
        end else begin
          // off-store load: one coordinate at least past the store's side
          r_row = twpb_pkg::COORD_W'($urandom);
          r_col = twpb_pkg::COORD_W'($urandom);
          if ($urandom_range(0, 1) == 0)
            r_row = twpb_pkg::COORD_W'($urandom_range(MARK_DIM, 4095));
          else
            r_col = twpb_pkg::COORD_W'($urandom_range(MARK_DIM, 4095));
          queue_load(r_row, r_col, rand_chan(), rand_chan(), rand_chan());
        end
      end
    end

    wait_idle();
    $display("Covered %0d texel loads and %0d pixels over %0d register settings,",
             n_loads, n_marks, n_phases);
    $display("%0d results checked (%0d blended), with a %0d-cycle output hold-off.",
             n_checked, n_blended, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("** tiled_watermark_pixel_blend_core: PASSED **");
    end else begin
      $display("%0d failures", n_errors);
      $display("** tiled_watermark_pixel_blend_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d results still outstanding", expected_px.size());
    $display("** tiled_watermark_pixel_blend_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/twpb_pkg.sv
hw/rtl/twpb_ram.sv
hw/rtl/tiled_watermark_pixel_blend_core.sv
tb/tiled_watermark_pixel_blend_core_tb.sv
